// ----- rtl/core/gedd_pkg.sv -----
// ----------------------------------------------------------------------------
// gedd_pkg
// Shared types and constants of the grayscale error-diffusion dither block.
// ----------------------------------------------------------------------------
package gedd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LEVELS_W   = 9;
  localparam int FWIDTH_W   = 11;
  localparam int FHEIGHT_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LEVELS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [LEVELS_W-1:0]  LEVELS_RESET       = 9'd4;
  localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

  // luma weights in thousandths
  localparam logic [9:0] COEF_R = 10'd299;
  localparam logic [9:0] COEF_G = 10'd587;
  localparam logic [9:0] COEF_B = 10'd114;

  // floor(s / 1000) = (s * RECIP_1000) >> RECIP_SHIFT for s < 2^18
  localparam logic [18:0] RECIP_1000  = 19'd268436;
  localparam int          RECIP_SHIFT = 28;

  // diffusion weights in sixteenths
  localparam logic [2:0] WT_UPLEFT  = 3'd1;
  localparam logic [2:0] WT_UP      = 3'd5;
  localparam logic [2:0] WT_UPRIGHT = 3'd3;
  localparam logic [2:0] WT_LEFT    = 3'd7;

  // per-pixel error, -255..255
  typedef logic signed [8:0] err_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] gray_out;
    logic       row_end;
    logic       frame_end;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LUMA,
    ST_ADD,
    ST_QUANT,
    ST_NUM,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic luma;
    logic add;
    logic quant;
    logic div_load;
    logic div_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic out_blocked;
  } sts_t;

endpackage

// ----- rtl/core/gedd_div.sv -----
// ----------------------------------------------------------------------------
// gedd_div
// Restoring divider, one quotient bit per step, 8-bit quotient.
// The caller guarantees num < 256 * den.
// ----------------------------------------------------------------------------
module gedd_div import gedd_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [16:0] num,
  input  logic [8:0]  den,
  output logic [7:0]  quot,
  output logic        last
);

  logic [8:0]  rem;
  logic [7:0]  shreg;
  logic [2:0]  cnt;
  logic [9:0]  trial;
  logic        qbit;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem, shreg[7]};
    qbit  = (trial >= {1'b0, den});
  end

  // dividend low bits shift out while quotient bits shift in
  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= num[16:8];
      shreg <= num[7:0];
      cnt   <= 3'd7;
    end else if (step) begin
      rem   <= qbit ? 9'(trial - {1'b0, den}) : trial[8:0];
      shreg <= {shreg[6:0], qbit};
      cnt   <= cnt - 3'd1;
    end
  end

  assign quot = shreg;
  assign last = (cnt == 3'd0);

endmodule

// ----- rtl/core/gedd_dp.sv -----
// ----------------------------------------------------------------------------
// gedd_dp
// Datapath: configuration registers, luma, error line store, diffusion adds,
// quantizer with level reconstruction, position counters, result register.
// ----------------------------------------------------------------------------
module gedd_dp import gedd_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  pixel_t                pixel,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  gray_stall,
  output logic                  gray_valid,
  output result_t               gray
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = (XW + 1 > FWIDTH_W + 1) ? XW + 1 : FWIDTH_W + 1;

  // configuration registers
  logic [LEVELS_W-1:0]  levels;
  logic [FWIDTH_W-1:0]  frame_width;
  logic [FHEIGHT_W-1:0] frame_height;

  // position and carried errors
  logic [XW-1:0]        col;
  logic [FHEIGHT_W-1:0] row;
  logic [XW-1:0]        clr;
  err_t                 left_carry;
  err_t                 upleft;

  // per-pixel working registers
  logic [17:0]          luma_sum;
  logic [7:0]           luma;
  logic [7:0]           v;
  logic [7:0]           idx;
  err_t                 rd0;
  err_t                 rd1;

  // line store of errors from the row above
  err_t                 mem [MAX_WIDTH];
  logic                 mem_we;
  logic [XW-1:0]        mem_addr;
  err_t                 mem_wdata;
  logic [XW-1:0]        rd1_addr;

  logic [LEVELS_W-1:0]  lv;
  logic [7:0]           lvm1;
  logic [CW-1:0]        w_eff;
  logic [FHEIGHT_W-1:0] h_eff;
  logic                 last_col;
  logic                 last_row;
  logic [36:0]          recip_prod;
  logic [7:0]           v_next;
  logic [16:0]          quant_prod;
  logic [16:0]          num;
  logic [7:0]           quot;
  logic                 div_last;
  err_t                 err;

  // floor(e*k/16) added to val, clamped to 0..255
  function automatic logic [7:0] add_part(input logic [7:0] val, input err_t e,
                                          input logic [2:0] k);
    logic signed [12:0] p;
    logic signed [8:0]  part;
    logic signed [10:0] s;
    logic [7:0]         r;
    p    = 13'(e) * $signed({10'b0, k});
    part = 9'(p >>> 4);
    s    = $signed({3'b000, val}) + 11'(part);
    if (s < 0) begin
      r = 8'd0;
    end else if (s > 11'sd255) begin
      r = 8'd255;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

  // effective configuration
  always_comb begin
    if (levels < 9'd2) begin
      lv = 9'd2;
    end else if (levels > 9'd256) begin
      lv = 9'd256;
    end else begin
      lv = levels;
    end
    lvm1 = 8'(lv - 9'd1);
    if (frame_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(frame_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    h_eff    = (frame_height == '0) ? FHEIGHT_W'(1) : frame_height;
    last_col = (CW'(col) + CW'(1) >= w_eff);
    last_row = ({1'b0, row} + 17'd1 >= {1'b0, h_eff});
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      levels       <= LEVELS_RESET;
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVELS:       levels       <= cfg_data[LEVELS_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // luma and reciprocal divide by 1000
  assign recip_prod = 37'(luma_sum) * 37'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      luma_sum <= 18'(18'(pixel.red) * 18'(COEF_R))
                + 18'(18'(pixel.green) * 18'(COEF_G))
                + 18'(18'(pixel.blue) * 18'(COEF_B));
    end
    if (cmd.luma) begin
      luma <= recip_prod[RECIP_SHIFT +: 8];
    end
  end

  // diffusion adds in order: up-left, up, up-right, left
  always_comb begin
    v_next = luma;
    if (row != '0) begin
      if (col != '0) begin
        v_next = add_part(v_next, upleft, WT_UPLEFT);
      end
      v_next = add_part(v_next, rd0, WT_UP);
      if (!last_col) begin
        v_next = add_part(v_next, rd1, WT_UPRIGHT);
      end
    end
    if (col != '0) begin
      v_next = add_part(v_next, left_carry, WT_LEFT);
    end
  end

  // quantize and build the reconstruction dividend
  assign quant_prod = 17'(v) * 17'(lv);
  assign num        = 17'(17'(idx) * 17'd510) + 17'(lvm1);

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      v <= v_next;
    end
    if (cmd.quant) begin
      idx <= quant_prod[15:8];
    end
  end

  // round(idx*255/(levels-1)) as (2*idx*255 + levels-1) / (2*(levels-1))
  gedd_div u_div (
    .clk  (clk),
    .load (cmd.div_load),
    .step (cmd.div_step),
    .num  (num),
    .den  ({lvm1, 1'b0}),
    .quot (quot),
    .last (div_last)
  );

  assign err = 9'($signed({2'b00, v}) - $signed({2'b00, quot}));

  // line store port selection
  always_comb begin
    mem_we    = cmd.clear || cmd.finish;
    mem_addr  = cmd.clear ? clr : col;
    mem_wdata = cmd.clear ? err_t'(0) : err;
    rd1_addr  = (col == XW'(MAX_WIDTH - 1)) ? '0 : XW'(col + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.accept) begin
      rd0 <= mem[col];
      rd1 <= mem[rd1_addr];
    end
  end

  // position, carried errors and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      clr        <= '0;
      left_carry <= '0;
      upleft     <= '0;
    end else begin
      if (cmd.clear) begin
        clr <= XW'(clr + 1'b1);
      end
      if (cmd.finish) begin
        upleft     <= rd0;
        left_carry <= last_col ? err_t'(0) : err;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : FHEIGHT_W'(row + 1'b1);
        end else begin
          col <= XW'(col + 1'b1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      gray_valid <= 1'b0;
    end else if (cmd.finish) begin
      gray_valid <= 1'b1;
    end else if (!gray_stall) begin
      gray_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      gray.gray_out  <= quot;
      gray.row_end   <= last_col;
      gray.frame_end <= last_col && last_row;
    end
  end

  assign sts.clear_last  = (clr == XW'(MAX_WIDTH - 1));
  assign sts.div_last    = div_last;
  assign sts.out_blocked = gray_valid && gray_stall;

endmodule

// ----- rtl/core/gedd_ctrl.sv -----
// ----------------------------------------------------------------------------
// gedd_ctrl
// Sequencer: line store clearing pass, then one pixel at a time through
// luma, diffusion, quantize, divide and write-back steps.
// ----------------------------------------------------------------------------
module gedd_ctrl import gedd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pixel_valid,
  output logic pixel_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    pixel_stall = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pixel_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LUMA;
        end
      end
      ST_LUMA: begin
        cmd.luma   = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_QUANT;
      end
      ST_QUANT: begin
        cmd.quant  = 1'b1;
        state_next = ST_NUM;
      end
      ST_NUM: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_blocked) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/gray_error_diffusion_dither_top.sv -----
// ----------------------------------------------------------------------------
// gray_error_diffusion_dither_top
// Grayscale error-diffusion dither of a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// a result is registered when its pixel leaves the sequencer's DONE state
// one pixel at a time, paced by the 8-step restoring divider that rebuilds the
//   output level plus the sequencer's other steps; a blocked result holds it
// reset: synchronous; a line store clearing pass over all MAX_WIDTH entries follows,
//   with pixel_stall high, while configuration writes are taken
module gray_error_diffusion_dither_top import gedd_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  gray_valid,
  input  logic                  gray_stall,
  output result_t               gray
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  gedd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath
  gedd_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel),
    .cmd        (cmd),
    .sts        (sts),
    .gray_stall (gray_stall),
    .gray_valid (gray_valid),
    .gray       (gray)
  );

  // one pixel at a time: no transaction in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> pixel_stall)
    else $error("pixel accepted while another is in work");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(gray_valid && gray_stall))
    else $error("result register overwritten while stalled");

  // sequencer issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  // frame end only on the last pixel of a row
  a_frame_end_row: assert property (@(posedge clk) disable iff (rst)
    gray_valid |-> (!gray.frame_end || gray.row_end))
    else $error("frame end without row end");

endmodule
